@@ sv/cdpa_pkg.sv @@
package cdpa_pkg;

  // data-processing opcodes, bits 24:21
  typedef enum logic [3:0] {
    OP_AND = 4'h0,
    OP_EOR = 4'h1,
    OP_SUB = 4'h2,
    OP_RSB = 4'h3,
    OP_ADD = 4'h4,
    OP_ADC = 4'h5,
    OP_SBC = 4'h6,
    OP_RSC = 4'h7,
    OP_TST = 4'h8,
    OP_TEQ = 4'h9,
    OP_CMP = 4'hA,
    OP_CMN = 4'hB,
    OP_ORR = 4'hC,
    OP_MOV = 4'hD,
    OP_BIC = 4'hE,
    OP_MVN = 4'hF
  } opcode_t;

  // condition codes, bits 31:28
  typedef enum logic [3:0] {
    COND_EQ = 4'h0,
    COND_NE = 4'h1,
    COND_CS = 4'h2,
    COND_CC = 4'h3,
    COND_MI = 4'h4,
    COND_PL = 4'h5,
    COND_VS = 4'h6,
    COND_VC = 4'h7,
    COND_HI = 4'h8,
    COND_LS = 4'h9,
    COND_GE = 4'hA,
    COND_LT = 4'hB,
    COND_GT = 4'hC,
    COND_LE = 4'hD,
    COND_AL = 4'hE,
    COND_NV = 4'hF
  } cond_t;

  // shift type, bits 6:5
  typedef enum logic [1:0] {
    SH_LSL = 2'd0,
    SH_LSR = 2'd1,
    SH_ASR = 2'd2,
    SH_ROR = 2'd3
  } shift_kind_t;

  localparam logic [3:0] PC_REG      = 4'hF;
  localparam logic [7:0] SHIFT_WORD  = 8'd32;

  // shifter output toward the alu
  typedef struct packed {
    logic [31:0] op2;
    logic        carry;
  } shift_res_t;

  // condition check against incoming nzcv
  function automatic logic cond_pass(input cond_t cond, input logic n, input logic z,
                                     input logic c, input logic v);
    logic pass;
    unique case (cond)
      COND_EQ: pass = z;
      COND_NE: pass = !z;
      COND_CS: pass = c;
      COND_CC: pass = !c;
      COND_MI: pass = n;
      COND_PL: pass = !n;
      COND_VS: pass = v;
      COND_VC: pass = !v;
      COND_HI: pass = c && !z;
      COND_LS: pass = !c || z;
      COND_GE: pass = (n == v);
      COND_LT: pass = (n != v);
      COND_GT: pass = !z && (n == v);
      COND_LE: pass = z || (n != v);
      COND_AL: pass = 1'b1;
      COND_NV: pass = 1'b0;
      default: pass = 1'b0;
    endcase
    return pass;
  endfunction

endpackage

@@ sv/cdpa_shifter.sv @@
module cdpa_shifter
  import cdpa_pkg::*;
(
  input  logic [31:0] instr,
  input  logic [31:0] rm,
  input  logic [7:0]  rs,
  input  logic        c_in,
  output shift_res_t  res
);

  logic [4:0]         rot;
  logic [63:0]        imm_w;
  logic [31:0]        imm_rot;
  shift_kind_t        kind;
  logic               reg_shift;
  logic               imm_zero;
  logic [7:0]         amt;
  logic [4:0]         sh5;
  logic [32:0]        lsl_w;
  logic [32:0]        lsr_w;
  logic signed [32:0] asr_w;
  logic [63:0]        ror_w;

  // rotated 8-bit immediate
  assign rot     = {instr[11:8], 1'b0};
  assign imm_w   = {24'd0, instr[7:0], 24'd0, instr[7:0]} >> rot;
  assign imm_rot = imm_w[31:0];

  // shift amount: register byte or 5-bit immediate, lsr/asr #0 mean 32
  assign kind      = shift_kind_t'(instr[6:5]);
  assign reg_shift = instr[4];
  assign imm_zero  = (instr[11:7] == 5'd0);
  always_comb begin
    if (reg_shift) begin
      amt = rs;
    end else if (imm_zero && (kind == SH_LSR || kind == SH_ASR)) begin
      amt = SHIFT_WORD;
    end else begin
      amt = {3'd0, instr[11:7]};
    end
  end
  assign sh5 = amt[4:0];

  // one extra bit on the lsl, lsr and asr shifters catches the last bit shifted out
  assign lsl_w = {1'b0, rm} << sh5;
  assign lsr_w = {rm, 1'b0} >> sh5;
  assign asr_w = $signed({rm, 1'b0}) >>> sh5;
  assign ror_w = {rm, rm} >> sh5;

  // pick operand 2 and shifter carry
  always_comb begin
    res = '{op2: rm, carry: c_in};
    if (instr[25]) begin
      res.op2   = imm_rot;
      res.carry = (rot == 5'd0) ? c_in : imm_rot[31];
    end else if (!reg_shift && imm_zero && kind == SH_ROR) begin
      // rrx
      res.op2   = {c_in, rm[31:1]};
      res.carry = rm[0];
    end else if (amt == 8'd0) begin
      res = '{op2: rm, carry: c_in};
    end else begin
      unique case (kind)
        SH_LSL: begin
          if (amt[7:5] == 3'd0) begin
            res = '{op2: lsl_w[31:0], carry: lsl_w[32]};
          end else begin
            res = '{op2: 32'd0, carry: (amt == SHIFT_WORD) ? rm[0] : 1'b0};
          end
        end
        SH_LSR: begin
          if (amt[7:5] == 3'd0) begin
            res = '{op2: lsr_w[32:1], carry: lsr_w[0]};
          end else begin
            res = '{op2: 32'd0, carry: (amt == SHIFT_WORD) ? rm[31] : 1'b0};
          end
        end
        SH_ASR: begin
          if (amt[7:5] == 3'd0) begin
            res = '{op2: asr_w[32:1], carry: asr_w[0]};
          end else begin
            res = '{op2: {32{rm[31]}}, carry: rm[31]};
          end
        end
        SH_ROR: begin
          res = '{op2: ror_w[31:0], carry: ror_w[31]};
        end
        default: res = '{op2: rm, carry: c_in};
      endcase
    end
  end

endmodule

@@ sv/cond_data_processing_alu_unit.sv @@
// data-processing execute stage: one instruction word in, one result item out
// input channel: in_valid/in_ready with the instruction, rn, rm, low byte of rs
//   and the current nzcv flags
// output channel: out_valid/out_ready with executed, alu result, write-back,
//   destination register, new nzcv and the psr restore request
// registers: an accepted item passes through two register stages on its way to the
//   outputs (input register, result register)
// throughput: one item per cycle while out_ready is high; the whole operation
//   (condition check, barrel shifter, 32-bit adder, flag logic) sits between the two registers
// stall: while out_ready is low the result register holds; the input register
//   still takes one more item, then in_ready drops until the result moves
// reset: rst_n low clears both valid flags; no item is in flight afterwards
// a skipped instruction returns result 0, no write-back and the flags unchanged
module cond_data_processing_alu_unit
  import cdpa_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_instruction,
  input  logic [31:0] in_rn_value,
  input  logic [31:0] in_rm_value,
  input  logic [7:0]  in_rs_low_byte,
  input  logic        in_flag_n_in,
  input  logic        in_flag_z_in,
  input  logic        in_flag_c_in,
  input  logic        in_flag_v_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_executed,
  output logic [31:0] out_alu_result,
  output logic        out_write_back,
  output logic [3:0]  out_dest_reg,
  output logic        out_flag_n_out,
  output logic        out_flag_z_out,
  output logic        out_flag_c_out,
  output logic        out_flag_v_out,
  output logic        out_psr_restore
);

  logic        s1_valid_r, s1_valid_nxt;
  logic [31:0] instr_r, rn_r, rm_r;
  logic [7:0]  rs_r;
  logic        n_r, z_r, c_r, v_r;
  logic        out_valid_r, out_valid_nxt;
  logic        advance;

  logic        ex_r, wb_r, psr_r, fn_r, fz_r, fc_r, fv_r;
  logic [31:0] res_r;
  logic [3:0]  rd_r;

  logic        ex, wb, psr, fn, fz, fc, fv;
  logic [31:0] res;
  opcode_t     op;
  logic        sbit;
  logic [3:0]  rd;
  shift_res_t  sh;
  logic        arith;
  logic [31:0] add_a, add_b;
  logic        add_cin;
  logic [32:0] sum;

  // handshake: result register moves when empty or taken
  assign advance       = !out_valid_r || out_ready;
  assign in_ready      = !s1_valid_r || advance;
  assign s1_valid_nxt  = (in_valid && in_ready) || (s1_valid_r && !advance);
  assign out_valid_nxt = advance ? s1_valid_r : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      instr_r <= in_instruction;
      rn_r    <= in_rn_value;
      rm_r    <= in_rm_value;
      rs_r    <= in_rs_low_byte;
      n_r     <= in_flag_n_in;
      z_r     <= in_flag_z_in;
      c_r     <= in_flag_c_in;
      v_r     <= in_flag_v_in;
    end
  end

  // operand 2
  cdpa_shifter u_shifter (
    .instr (instr_r),
    .rm    (rm_r),
    .rs    (rs_r),
    .c_in  (c_r),
    .res   (sh)
  );

  assign op   = opcode_t'(instr_r[24:21]);
  assign sbit = instr_r[20];
  assign rd   = instr_r[15:12];
  assign ex   = cond_pass(cond_t'(instr_r[31:28]), n_r, z_r, c_r, v_r);

  // adder operand selection and logical results
  always_comb begin
    arith   = 1'b0;
    add_a   = rn_r;
    add_b   = sh.op2;
    add_cin = 1'b0;
    res     = 32'd0;
    unique case (op)
      OP_AND, OP_TST: res = rn_r & sh.op2;
      OP_EOR, OP_TEQ: res = rn_r ^ sh.op2;
      OP_SUB, OP_CMP: begin
        arith = 1'b1; add_b = ~sh.op2; add_cin = 1'b1;
      end
      OP_RSB: begin
        arith = 1'b1; add_a = sh.op2; add_b = ~rn_r; add_cin = 1'b1;
      end
      OP_ADD, OP_CMN: arith = 1'b1;
      OP_ADC: begin
        arith = 1'b1; add_cin = c_r;
      end
      OP_SBC: begin
        arith = 1'b1; add_b = ~sh.op2; add_cin = c_r;
      end
      OP_RSC: begin
        arith = 1'b1; add_a = sh.op2; add_b = ~rn_r; add_cin = c_r;
      end
      OP_ORR: res = rn_r | sh.op2;
      OP_MOV: res = sh.op2;
      OP_BIC: res = rn_r & ~sh.op2;
      OP_MVN: res = ~sh.op2;
      default: res = 32'd0;
    endcase
    if (arith) begin
      res = sum[31:0];
    end
  end

  assign sum = {1'b0, add_a} + {1'b0, add_b} + {32'd0, add_cin};

  // flags, write-back and psr restore
  always_comb begin
    fn  = n_r;
    fz  = z_r;
    fc  = c_r;
    fv  = v_r;
    wb  = 1'b0;
    psr = 1'b0;
    if (ex) begin
      wb = !(op == OP_TST || op == OP_TEQ || op == OP_CMP || op == OP_CMN);
      if (sbit) begin
        if (rd == PC_REG) begin
          psr = 1'b1;
        end else begin
          fn = res[31];
          fz = (res == 32'd0);
          if (arith) begin
            fc = sum[32];
            fv = ((add_a[31] ^ res[31]) & (add_b[31] ^ res[31]));
          end else begin
            fc = sh.carry;
          end
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (advance && s1_valid_r) begin
      ex_r  <= ex;
      res_r <= ex ? res : 32'd0;
      wb_r  <= wb;
      rd_r  <= rd;
      fn_r  <= fn;
      fz_r  <= fz;
      fc_r  <= fc;
      fv_r  <= fv;
      psr_r <= psr;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_executed    = ex_r;
  assign out_alu_result  = res_r;
  assign out_write_back  = wb_r;
  assign out_dest_reg    = rd_r;
  assign out_flag_n_out  = fn_r;
  assign out_flag_z_out  = fz_r;
  assign out_flag_c_out  = fc_r;
  assign out_flag_v_out  = fv_r;
  assign out_psr_restore = psr_r;

endmodule

@@ sv/cdpa_checker.sv @@
module cdpa_checker
  import cdpa_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_executed,
  input logic [31:0] out_alu_result,
  input logic        out_write_back,
  input logic [3:0]  out_dest_reg,
  input logic        out_psr_restore
);

  // a stalled item stays on the output
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_alu_result))
    else $error("output item dropped while stalled");

  // a skipped instruction has no side effects
  a_skip_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_executed |->
      !out_write_back && !out_psr_restore && out_alu_result == 32'd0)
    else $error("skipped instruction has side effects");

  // psr restore only for executed writes to the pc
  a_psr_pc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_psr_restore |-> out_executed && out_dest_reg == PC_REG)
    else $error("psr restore without executed pc destination");

  // reset leaves no item on the output
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind cond_data_processing_alu_unit cdpa_checker u_cdpa_checker (.*);

@@ dv/cond_data_processing_alu_unit_tb.sv @@
`timescale 1ns / 100ps

module cond_data_processing_alu_unit_tb;
  import cdpa_pkg::*;

  localparam int          WATCHDOG_LIMIT = 5000;
  localparam int          HOLD_CYCLES    = 100;
  localparam int          RANDOM_ITEMS   = 1600;
  localparam int          SEGMENT_ITEMS  = 100;
  localparam int          MAX_REPORTS    = 10;

  // one result item as the block reports it
  typedef struct packed {
    logic        executed;
    logic [31:0] alu_result;
    logic        write_back;
    logic [3:0]  dest_reg;
    logic        flag_n;
    logic        flag_z;
    logic        flag_c;
    logic        flag_v;
    logic        psr_restore;
  } dp_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] in_instruction = '0;
  logic [31:0] in_rn_value = '0;
  logic [31:0] in_rm_value = '0;
  logic [7:0]  in_rs_low_byte = '0;
  logic        in_flag_n_in = 1'b0;
  logic        in_flag_z_in = 1'b0;
  logic        in_flag_c_in = 1'b0;
  logic        in_flag_v_in = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_executed;
  logic [31:0] out_alu_result;
  logic        out_write_back;
  logic [3:0]  out_dest_reg;
  logic        out_flag_n_out;
  logic        out_flag_z_out;
  logic        out_flag_c_out;
  logic        out_flag_v_out;
  logic        out_psr_restore;

  dp_result_t  pending_results[$];
  int          mismatches = 0;
  int          items_sent = 0;
  int          results_seen = 0;
  int          executed_seen = 0;
  int          skipped_seen = 0;
  int          psr_seen = 0;
  int          idle_cycles = 0;
  int          rx_stall_left = 0;
  int          hold_cnt = 0;
  logic        tx_idle_en = 1'b0;
  logic        rx_idle_en = 1'b0;
  logic        hold_req = 1'b0;

  cond_data_processing_alu_unit u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_instruction  (in_instruction),
    .in_rn_value     (in_rn_value),
    .in_rm_value     (in_rm_value),
    .in_rs_low_byte  (in_rs_low_byte),
    .in_flag_n_in    (in_flag_n_in),
    .in_flag_z_in    (in_flag_z_in),
    .in_flag_c_in    (in_flag_c_in),
    .in_flag_v_in    (in_flag_v_in),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_executed    (out_executed),
    .out_alu_result  (out_alu_result),
    .out_write_back  (out_write_back),
    .out_dest_reg    (out_dest_reg),
    .out_flag_n_out  (out_flag_n_out),
    .out_flag_z_out  (out_flag_z_out),
    .out_flag_c_out  (out_flag_c_out),
    .out_flag_v_out  (out_flag_v_out),
    .out_psr_restore (out_psr_restore)
  );

  // clock
  always #4 clk = ~clk;

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  function automatic logic [31:0] rotr32(input logic [31:0] x, input int unsigned r);
    int unsigned k;
    k = r % 32;
    if (k == 0) return x;
    return (x >> k) | (x << (32 - k));
  endfunction

  function automatic logic cond_ok(input cond_t cond, input logic n, input logic z,
                                   input logic c, input logic v);
    case (cond)
      COND_EQ: return z;
      COND_NE: return !z;
      COND_CS: return c;
      COND_CC: return !c;
      COND_MI: return n;
      COND_PL: return !n;
      COND_VS: return v;
      COND_VC: return !v;
      COND_HI: return c && !z;
      COND_LS: return !c || z;
      COND_GE: return n == v;
      COND_LT: return n != v;
      COND_GT: return !z && (n == v);
      COND_LE: return z || (n != v);
      COND_AL: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  // operand 2 and the shifter carry
  function automatic logic [31:0] operand2(input logic [31:0] insn, input logic [31:0] rm,
                                           input logic [7:0] rs, input logic cin,
                                           output logic cout);
    shift_kind_t kind;
    int unsigned amt;
    int unsigned rot;
    logic [31:0] r;
    kind = shift_kind_t'(insn[6:5]);
    // rotated 8-bit immediate
    if (insn[25]) begin
      rot  = insn[11:8] * 2;
      r    = rotr32({24'd0, insn[7:0]}, rot);
      cout = (rot == 0) ? cin : r[31];
      return r;
    end
    if (insn[4]) begin
      amt = rs;
      if (amt == 0) begin
        cout = cin;
        return rm;
      end
    end else begin
      amt = insn[11:7];
      // zero immediate amount: lsl passes, lsr/asr by 32, ror becomes rrx
      if (amt == 0) begin
        case (kind)
          SH_LSL: begin
            cout = cin;
            return rm;
          end
          SH_LSR, SH_ASR: amt = 32;
          default: begin
            cout = rm[0];
            return {cin, rm[31:1]};
          end
        endcase
      end
    end
    case (kind)
      SH_LSL: begin
        if (amt < 32) begin
          cout = rm[32 - amt];
          r    = rm << amt;
        end else begin
          cout = (amt == 32) ? rm[0] : 1'b0;
          r    = '0;
        end
      end
      SH_LSR: begin
        if (amt < 32) begin
          cout = rm[amt - 1];
          r    = rm >> amt;
        end else begin
          cout = (amt == 32) ? rm[31] : 1'b0;
          r    = '0;
        end
      end
      SH_ASR: begin
        if (amt < 32) begin
          cout = rm[amt - 1];
          r    = $signed(rm) >>> amt;
        end else begin
          cout = rm[31];
          r    = {32{rm[31]}};
        end
      end
      default: begin
        if (amt % 32 == 0) begin
          cout = rm[31];
          r    = rm;
        end else begin
          cout = rm[(amt % 32) - 1];
          r    = rotr32(rm, amt);
        end
      end
    endcase
    return r;
  endfunction

  function automatic dp_result_t predict_dp(input logic [31:0] insn, input logic [31:0] rn,
                                            input logic [31:0] rm, input logic [7:0] rs,
                                            input logic [3:0] nzcv);
    dp_result_t  p;
    opcode_t     op;
    logic        s;
    logic        arith;
    logic        sh_carry;
    logic        cin;
    logic [31:0] op2;
    logic [31:0] a;
    logic [31:0] b;
    logic [32:0] sum;
    op    = opcode_t'(insn[24:21]);
    s     = insn[20];
    p     = '0;
    p.dest_reg = insn[15:12];
    {p.flag_n, p.flag_z, p.flag_c, p.flag_v} = nzcv;
    if (cond_ok(cond_t'(insn[31:28]), nzcv[3], nzcv[2], nzcv[1], nzcv[0])) begin
      p.executed = 1'b1;
      op2   = operand2(insn, rm, rs, nzcv[1], sh_carry);
      arith = 1'b0;
      a     = '0;
      b     = '0;
      cin   = 1'b0;
      case (op)
        OP_AND, OP_TST: p.alu_result = rn & op2;
        OP_EOR, OP_TEQ: p.alu_result = rn ^ op2;
        OP_SUB, OP_CMP: begin arith = 1'b1; a = rn;  b = ~op2; cin = 1'b1;    end
        OP_RSB:         begin arith = 1'b1; a = op2; b = ~rn;  cin = 1'b1;    end
        OP_ADD, OP_CMN: begin arith = 1'b1; a = rn;  b = op2;  cin = 1'b0;    end
        OP_ADC:         begin arith = 1'b1; a = rn;  b = op2;  cin = nzcv[1]; end
        OP_SBC:         begin arith = 1'b1; a = rn;  b = ~op2; cin = nzcv[1]; end
        OP_RSC:         begin arith = 1'b1; a = op2; b = ~rn;  cin = nzcv[1]; end
        OP_ORR:         p.alu_result = rn | op2;
        OP_MOV:         p.alu_result = op2;
        OP_BIC:         p.alu_result = rn & ~op2;
        default:        p.alu_result = ~op2;
      endcase
      // carry and overflow, left alone on a flagged write to the pc
      if (arith) begin
        sum = {1'b0, a} + {1'b0, b} + {32'd0, cin};
        p.alu_result = sum[31:0];
        if (s && p.dest_reg != PC_REG) begin
          p.flag_c = sum[32];
          p.flag_v = (a[31] ^ sum[31]) & (b[31] ^ sum[31]);
        end
      end else if (s && p.dest_reg != PC_REG) begin
        p.flag_c = sh_carry;
      end
      if (s) begin
        if (p.dest_reg == PC_REG) begin
          p.psr_restore = 1'b1;
        end else begin
          p.flag_n = p.alu_result[31];
          p.flag_z = (p.alu_result == 32'd0);
        end
      end
      p.write_back = !(op == OP_TST || op == OP_TEQ || op == OP_CMP || op == OP_CMN);
    end
    return p;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic logic [31:0] dp_insn(input cond_t cond, input logic imm, input opcode_t op,
                                          input logic s, input logic [3:0] rd,
                                          input logic [11:0] op2);
    return {cond, 2'b00, imm, op, s, 4'h1, rd, op2};
  endfunction

  // operand 2 encodings: rm shifted by an immediate amount or by rs
  function automatic logic [11:0] imm_shift(input shift_kind_t kind, input logic [4:0] amt);
    return {amt, kind, 1'b0, 4'h2};
  endfunction

  function automatic logic [11:0] reg_shift(input shift_kind_t kind, input logic bit7);
    return {4'h3, bit7, kind, 1'b1, 4'h2};
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h8000_0000;
      3:       return 32'h7FFF_FFFF;
      4:       return 32'h0000_0001;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [7:0] pick_amount();
    case ($urandom_range(0, 9))
      0:       return 8'd0;
      1:       return 8'd1;
      2:       return 8'd31;
      3:       return 8'd32;
      4:       return 8'd33;
      5:       return 8'd64;
      6:       return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // send one item; called and returning at a falling edge
  task automatic send_item(input logic [31:0] insn, input logic [31:0] rn,
                           input logic [31:0] rm, input logic [7:0] rs,
                           input logic [3:0] nzcv);
    int gap;
    in_instruction = insn;
    in_rn_value    = rn;
    in_rm_value    = rm;
    in_rs_low_byte = rs;
    {in_flag_n_in, in_flag_z_in, in_flag_c_in, in_flag_v_in} = nzcv;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(predict_dp(insn, rn, rm, rs, nzcv));
    items_sent++;
    @(negedge clk);
    gap = (tx_idle_en && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic stop_sending();
    in_valid = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // all sixteen opcodes with extreme operands, mixing immediate and shifted rm
  task automatic test_opcodes();
    logic [31:0] rn_tab[4];
    logic [31:0] rm_tab[4];
    logic [11:0] op2;
    logic        imm;
    rn_tab = '{32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0000};
    rm_tab = '{32'h0000_0001, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};
    for (int i = 0; i < 16; i++) begin
      imm = (i % 3 == 1);
      op2 = imm ? {4'(i), 8'h81} : imm_shift(SH_LSL, 5'(i));
      send_item(dp_insn(COND_AL, imm, opcode_t'(i), 1'b1, 4'(i % 15), op2),
                rn_tab[i % 4], rm_tab[(i / 4) % 4], 8'hFF, 4'(i));
    end
    stop_sending();
  endtask

  // condition never, flags untouched, flagged pc write and shifter corner encodings
  task automatic test_special_cases();
    send_item(dp_insn(COND_NV, 1'b0, OP_MOV, 1'b1, 4'h4, imm_shift(SH_LSL, 5'd0)),
              32'h1234_5678, 32'hFFFF_FFFF, 8'd0, 4'b0000);
    send_item(dp_insn(COND_AL, 1'b0, OP_CMP, 1'b0, 4'h5, imm_shift(SH_LSL, 5'd0)),
              32'h0000_0005, 32'h0000_0005, 8'd0, 4'b1010);
    send_item(dp_insn(COND_AL, 1'b1, OP_MOV, 1'b1, PC_REG, 12'h000),
              32'h0, 32'h0, 8'd0, 4'b0101);
    // zero immediate shift amounts
    send_item(dp_insn(COND_AL, 1'b0, OP_MOV, 1'b1, 4'h6, imm_shift(SH_LSL, 5'd0)),
              32'h0, 32'h8000_0001, 8'd0, 4'b0010);
    send_item(dp_insn(COND_AL, 1'b0, OP_MOV, 1'b1, 4'h6, imm_shift(SH_LSR, 5'd0)),
              32'h0, 32'h8000_0001, 8'd0, 4'b0000);
    send_item(dp_insn(COND_AL, 1'b0, OP_MOV, 1'b1, 4'h6, imm_shift(SH_ASR, 5'd0)),
              32'h0, 32'h8000_0001, 8'd0, 4'b0000);
    send_item(dp_insn(COND_AL, 1'b0, OP_MOV, 1'b1, 4'h6, imm_shift(SH_ROR, 5'd0)),
              32'h0, 32'h8000_0001, 8'd0, 4'b0010);
    // register amounts of 32 and beyond, and zero with bit 7 set
    send_item(dp_insn(COND_AL, 1'b0, OP_MOV, 1'b1, 4'h7, reg_shift(SH_LSL, 1'b0)),
              32'h0, 32'h0000_0001, 8'd32, 4'b0000);
    send_item(dp_insn(COND_AL, 1'b0, OP_MOV, 1'b1, 4'h7, reg_shift(SH_LSR, 1'b0)),
              32'h0, 32'hFFFF_FFFF, 8'd40, 4'b0010);
    send_item(dp_insn(COND_AL, 1'b0, OP_MOV, 1'b1, 4'h7, reg_shift(SH_ASR, 1'b0)),
              32'h0, 32'h8000_0000, 8'd255, 4'b0000);
    send_item(dp_insn(COND_AL, 1'b0, OP_MOV, 1'b1, 4'h7, reg_shift(SH_ROR, 1'b0)),
              32'h0, 32'h8000_0000, 8'd64, 4'b0000);
    send_item(dp_insn(COND_AL, 1'b0, OP_MOV, 1'b1, 4'h7, reg_shift(SH_ROR, 1'b1)),
              32'h0, 32'h8765_4321, 8'd0, 4'b0010);
    stop_sending();
  endtask

  // random instructions in segments, each with its own idling mode
  task automatic test_random();
    logic [31:0] insn;
    logic [11:0] op2;
    logic        imm;
    cond_t       cond;
    logic [3:0]  rd;
    int          mode;
    for (int seg = 0; seg < RANDOM_ITEMS / SEGMENT_ITEMS; seg++) begin
      mode       = (seg == 0) ? 0 : $urandom_range(0, 3);
      tx_idle_en = mode[0];
      rx_idle_en = mode[1];
      for (int i = 0; i < SEGMENT_ITEMS; i++) begin
        cond = ($urandom_range(0, 1) == 0) ? COND_AL : cond_t'($urandom_range(0, 15));
        imm  = 1'($urandom_range(0, 1));
        rd   = ($urandom_range(0, 7) == 0) ? PC_REG : 4'($urandom_range(0, 15));
        op2  = 12'($urandom);
        if (!imm && !op2[4] && $urandom_range(0, 2) == 0)
          op2[11:7] = ($urandom_range(0, 2) == 0) ? 5'd0 :
                      ($urandom_range(0, 1) == 0) ? 5'd1 : 5'd31;
        insn = dp_insn(cond, imm, opcode_t'($urandom_range(0, 15)),
                       1'($urandom_range(0, 1)), rd, op2);
        insn[19:16] = 4'($urandom);
        insn[27:26] = 2'($urandom);
        send_item(insn, pick_word(), pick_word(), pick_amount(), 4'($urandom));
      end
    end
    stop_sending();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
  endtask

  // receiver holds off while items keep coming, so the block backs up
  task automatic test_backpressure();
    hold_req = 1'b1;
    for (int i = 0; i < 16; i++)
      send_item(dp_insn(COND_AL, 1'b0, opcode_t'(i), 1'b1, 4'(i % 15),
                        imm_shift(SH_ROR, 5'(i))),
                pick_word(), pick_word(), pick_amount(), 4'($urandom));
    stop_sending();
    while (hold_req) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // receiver, checker, watchdog
  // ---------------------------------------------------------------------------

  // out_ready: long hold on request, otherwise random stalls when enabled
  always @(negedge clk) begin
    if (hold_req) begin
      out_ready <= 1'b0;
      hold_cnt++;
      if (hold_cnt >= HOLD_CYCLES) begin
        hold_cnt = 0;
        hold_req = 1'b0;
      end
    end else if (rx_stall_left > 0) begin
      out_ready <= 1'b0;
      rx_stall_left--;
    end else begin
      out_ready <= 1'b1;
      if (rx_idle_en && $urandom_range(0, 3) == 0) rx_stall_left = pick_gap();
    end
  end

  task automatic note_field(input string name, input logic [31:0] exp_val,
                            input logic [31:0] act_val);
    if (exp_val !== act_val) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("[%0t] %s: expected %h, got %h", $realtime, name, exp_val, act_val);
    end
  endtask

  // compare each accepted result item with the oldest prediction
  always @(posedge clk) begin : check_results
    dp_result_t exp_item;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("[%0t] result item with nothing pending: result %h", $realtime,
                   out_alu_result);
      end else begin
        exp_item = pending_results.pop_front();
        note_field("executed", 32'(exp_item.executed), 32'(out_executed));
        note_field("alu_result", exp_item.alu_result, out_alu_result);
        note_field("write_back", 32'(exp_item.write_back), 32'(out_write_back));
        note_field("dest_reg", 32'(exp_item.dest_reg), 32'(out_dest_reg));
        note_field("flag_n", 32'(exp_item.flag_n), 32'(out_flag_n_out));
        note_field("flag_z", 32'(exp_item.flag_z), 32'(out_flag_z_out));
        note_field("flag_c", 32'(exp_item.flag_c), 32'(out_flag_c_out));
        note_field("flag_v", 32'(exp_item.flag_v), 32'(out_flag_v_out));
        note_field("psr_restore", 32'(exp_item.psr_restore), 32'(out_psr_restore));
        if (exp_item.executed) executed_seen++;
        else skipped_seen++;
        if (exp_item.psr_restore) psr_seen++;
      end
    end
  end

  // end the run if neither side moves an item for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_n = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_opcodes();
    test_special_cases();
    test_random();
    test_backpressure();

    // drain, then let the pipeline settle
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("%0d items sent, %0d results checked (%0d executed, %0d skipped, %0d psr restores)",
             items_sent, results_seen, executed_seen, skipped_seen, psr_seen);
    $display("covered all opcodes and conditions, both operand-2 forms and a long output stall");
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d field mismatches", mismatches);
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
